// File: rtl/lrs_pkg.sv
// Shared types and constants for the rolling LULU smoother.
`timescale 1ns / 1ps

package lrs_pkg;

    // Width of the filter order register and of every order-sized counter.
    localparam int ORD_W = 4;

    typedef logic [ORD_W-1:0] order_t;

    // Flatten flags for the two windows: lo is the sample window, hi the negated one.
    typedef struct packed {
        logic lo;
        logic hi;
    } fix_t;

endpackage

// File: rtl/lrs_window_ram.sv
// Dual window store: one write port and two registered read ports shared by both windows.
`timescale 1ns / 1ps

module lrs_window_ram #(
    parameter int DEPTH = 31,
    parameter int DW = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic           clk,
    input  lrs_pkg::fix_t  we,
    input  logic [AW-1:0]  waddr,
    input  logic [DW-1:0]  wdata_lo,
    input  logic [DW-1:0]  wdata_hi,
    input  logic [AW-1:0]  raddr_a,
    input  logic [AW-1:0]  raddr_b,
    output logic [DW-1:0]  rdata_a_lo,
    output logic [DW-1:0]  rdata_a_hi,
    output logic [DW-1:0]  rdata_b_lo,
    output logic [DW-1:0]  rdata_b_hi
);

    logic [DW-1:0] lo_mem [DEPTH];
    logic [DW-1:0] hi_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we.lo)
        begin
            lo_mem[waddr] <= wdata_lo;
        end
        if (we.hi)
        begin
            hi_mem[waddr] <= wdata_hi;
        end
        rdata_a_lo <= lo_mem[raddr_a];
        rdata_a_hi <= hi_mem[raddr_a];
        rdata_b_lo <= lo_mem[raddr_b];
        rdata_b_hi <= hi_mem[raddr_b];
    end

endmodule

// File: rtl/lrs_cmp_unit.sv
// Shared compare and select unit that detects bumps and pits and picks the flatten value.
`timescale 1ns / 1ps

module lrs_cmp_unit #(
    parameter int DW = 16
) (
    input  logic                 pass,
    input  logic signed [DW-1:0] prev_lo,
    input  logic signed [DW-1:0] cur_lo,
    input  logic signed [DW-1:0] next_lo,
    input  logic signed [DW-1:0] prev_hi,
    input  logic signed [DW-1:0] cur_hi,
    input  logic signed [DW-1:0] next_hi,
    output lrs_pkg::fix_t        fix,
    output logic signed [DW-1:0] fill_lo,
    output logic signed [DW-1:0] fill_hi,
    output logic signed [DW-1:0] upd_lo,
    output logic signed [DW-1:0] upd_hi
);

    logic                 bump_lo;
    logic                 pit_lo;
    logic                 bump_hi;
    logic                 pit_hi;
    logic signed [DW-1:0] max_lo;
    logic signed [DW-1:0] min_lo;
    logic signed [DW-1:0] max_hi;
    logic signed [DW-1:0] min_hi;

    assign bump_lo = (prev_lo < cur_lo) && (cur_lo > next_lo);
    assign pit_lo  = (prev_lo > cur_lo) && (cur_lo < next_lo);
    assign bump_hi = (prev_hi < cur_hi) && (cur_hi > next_hi);
    assign pit_hi  = (prev_hi > cur_hi) && (cur_hi < next_hi);

    assign max_lo = (prev_lo > next_lo) ? prev_lo : next_lo;
    assign min_lo = (prev_lo < next_lo) ? prev_lo : next_lo;
    assign max_hi = (prev_hi > next_hi) ? prev_hi : next_hi;
    assign min_hi = (prev_hi < next_hi) ? prev_hi : next_hi;

    // The first sweep removes bumps in the sample window and pits in the negated one;
    // the second sweep does the opposite. In the first sweep a bump fix keeps the
    // running sample value as it was read.
    always_comb
    begin
        if (!pass)
        begin
            fix.lo  = bump_lo;
            fill_lo = max_lo;
            upd_lo  = cur_lo;
            fix.hi  = pit_hi;
            fill_hi = min_hi;
            upd_hi  = pit_hi ? min_hi : cur_hi;
        end
        else
        begin
            fix.lo  = pit_lo;
            fill_lo = min_lo;
            upd_lo  = pit_lo ? min_lo : cur_lo;
            fix.hi  = bump_hi;
            fill_hi = max_hi;
            upd_hi  = bump_hi ? max_hi : cur_hi;
        end
    end

endmodule

// File: rtl/lulu_rolling_smoother.sv
// Top level of the rolling LULU smoother: sequencer, windows and output register.
//
// Usage:
// The sample channel takes one signed sample per beat (sample_valid, sample_stall);
// the smoothed channel gives one result per input beat (smoothed_valid,
// smoothed_stall). The block works on one sample at a time and holds sample_stall
// high until that sample's result is loaded into the output register.
// The next sample can be taken as soon as the result is in the output register.
// Every run that gets flattened is written back over n positions, n being the order
// of that sweep, and unless it was the sweep's last position the windows are then
// read again, since the store's reads are registered.
// filter_order is to be written through filter_order_we only while the block is idle;
// the block itself does not enforce this. Values of 0 become 1 and values above
// MAX_ORDER become MAX_ORDER. Each write, and reset, starts a clearing pass that
// zeroes all 2*MAX_ORDER+1 entries of both windows; no sample is taken during it.
// The result sits in an output register, so a stalled receiver delays only the
// end of the next sample's processing, never the acceptance of that sample.
`timescale 1ns / 1ps

module lulu_rolling_smoother #(
    parameter int MAX_ORDER = 15,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          filter_order_we,
    input  logic [3:0]                    filter_order,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic                          smoothed_valid,
    input  logic                          smoothed_stall,
    output logic signed [SAMPLE_BITS-1:0] smoothed
);

    import lrs_pkg::*;

    localparam int DW = SAMPLE_BITS;
    localparam int DEPTH = 2 * MAX_ORDER + 1;
    localparam int AW = $clog2(DEPTH);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RDBASE = 3'd2;
    localparam logic [2:0] ST_RD     = 3'd3;
    localparam logic [2:0] ST_EVAL   = 3'd4;
    localparam logic [2:0] ST_FILL   = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam logic signed [DW-1:0] SMP_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] SMP_MAX = {1'b0, {(DW-1){1'b1}}};

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x,
                                               input logic [AW-1:0] sz);
        return (x == sz - AW'(1)) ? '0 : x + AW'(1);
    endfunction

    // Control registers
    logic [2:0]    state_reg, state_next;
    order_t        order_reg, order_next;
    logic [AW-1:0] wpos_reg, wpos_next;
    logic [AW-1:0] clr_reg, clr_next;
    order_t        n_reg, n_next;
    order_t        i_reg, i_next;
    logic          pass_reg, pass_next;
    order_t        fill_cnt_reg, fill_cnt_next;
    fix_t          fill_en_reg, fill_en_next;
    logic          out_valid_reg, out_valid_next;

    // Datapath registers
    logic [AW-1:0]        idx_reg, idx_next;
    logic [AW-1:0]        ci_reg, ci_next;
    logic [AW-1:0]        ni_reg, ni_next;
    logic [AW-1:0]        fill_addr_reg, fill_addr_next;
    logic signed [DW-1:0] prev_lo_reg, prev_lo_next;
    logic signed [DW-1:0] prev_hi_reg, prev_hi_next;
    logic signed [DW-1:0] fill_lo_reg, fill_lo_next;
    logic signed [DW-1:0] fill_hi_reg, fill_hi_next;
    logic signed [DW-1:0] out_data_reg, out_data_next;

    // Combinational signals
    logic                 in_accept;
    logic [AW-1:0]        size;
    logic [AW-1:0]        two_n;
    logic [AW-1:0]        base;
    logic [AW-1:0]        ci0;
    logic [AW:0]          ni0_wide;
    logic [AW-1:0]        ni0;
    logic [AW-1:0]        idx_now;
    logic signed [DW-1:0] neg_sample;
    logic                 last_iter;
    logic                 last_order;
    logic                 do_adv;
    logic signed [DW:0]   diff;
    order_t               cfg_order;
    logic [AW:0]          ni_chk_wide;
    logic [AW-1:0]        ni_chk;

    // Window store ports
    fix_t                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic signed [DW-1:0] mem_wdata_lo;
    logic signed [DW-1:0] mem_wdata_hi;
    logic [AW-1:0]        mem_raddr_a;
    logic [AW-1:0]        mem_raddr_b;
    logic signed [DW-1:0] rd_a_lo;
    logic signed [DW-1:0] rd_a_hi;
    logic signed [DW-1:0] rd_b_lo;
    logic signed [DW-1:0] rd_b_hi;

    // Compare unit ports
    fix_t                 fix;
    logic signed [DW-1:0] cmp_fill_lo;
    logic signed [DW-1:0] cmp_fill_hi;
    logic signed [DW-1:0] upd_lo;
    logic signed [DW-1:0] upd_hi;

    lrs_window_ram #(
        .DEPTH (DEPTH),
        .DW    (DW)
    ) u_ram (
        .clk        (clk),
        .we         (mem_we),
        .waddr      (mem_waddr),
        .wdata_lo   (mem_wdata_lo),
        .wdata_hi   (mem_wdata_hi),
        .raddr_a    (mem_raddr_a),
        .raddr_b    (mem_raddr_b),
        .rdata_a_lo (rd_a_lo),
        .rdata_a_hi (rd_a_hi),
        .rdata_b_lo (rd_b_lo),
        .rdata_b_hi (rd_b_hi)
    );

    lrs_cmp_unit #(
        .DW (DW)
    ) u_cmp (
        .pass    (pass_reg),
        .prev_lo (prev_lo_reg),
        .cur_lo  (rd_a_lo),
        .next_lo (rd_b_lo),
        .prev_hi (prev_hi_reg),
        .cur_hi  (rd_a_hi),
        .next_hi (rd_b_hi),
        .fix     (fix),
        .fill_lo (cmp_fill_lo),
        .fill_hi (cmp_fill_hi),
        .upd_lo  (upd_lo),
        .upd_hi  (upd_hi)
    );

    assign sample_stall   = (state_reg != ST_IDLE);
    assign in_accept      = sample_valid && !sample_stall;
    assign smoothed_valid = out_valid_reg;
    assign smoothed       = out_data_reg;

    assign size  = AW'({order_reg, 1'b1});
    assign two_n = AW'({n_reg, 1'b0});

    // Oldest position touched by the current order, two times the order back from
    // the newest sample.
    always_comb
    begin
        if (idx_reg >= two_n)
        begin
            base = idx_reg - two_n;
        end
        else
        begin
            base = idx_reg + (size - two_n);
        end
    end

    assign ci0      = wrap_inc(base, size);
    assign ni0_wide = {1'b0, ci0} + (AW+1)'(n_reg);
    assign ni0      = (ni0_wide >= {1'b0, size}) ? AW'(ni0_wide - {1'b0, size})
                                                 : AW'(ni0_wide);

    assign idx_now    = (wpos_reg >= size) ? '0 : wpos_reg;
    assign neg_sample = (sample == SMP_MIN) ? SMP_MAX : -sample;

    assign last_iter  = (i_reg == n_reg - order_t'(1));
    assign last_order = (n_reg == order_reg);

    assign diff = {prev_lo_reg[DW-1], prev_lo_reg} - {prev_hi_reg[DW-1], prev_hi_reg};

    always_comb
    begin
        if (filter_order == '0)
        begin
            cfg_order = order_t'(1);
        end
        else if (32'(filter_order) > MAX_ORDER)
        begin
            cfg_order = order_t'(MAX_ORDER);
        end
        else
        begin
            cfg_order = order_t'(filter_order);
        end
    end

    // Window store write and read address selection.
    always_comb
    begin
        mem_we       = '0;
        mem_waddr    = fill_addr_reg;
        mem_wdata_lo = fill_lo_reg;
        mem_wdata_hi = fill_hi_reg;
        mem_raddr_a  = ci_reg;
        mem_raddr_b  = ni_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we       = '{lo: 1'b1, hi: 1'b1};
                mem_waddr    = clr_reg;
                mem_wdata_lo = '0;
                mem_wdata_hi = '0;
            end
            ST_IDLE:
            begin
                mem_we       = '{lo: in_accept, hi: in_accept};
                mem_waddr    = idx_now;
                mem_wdata_lo = sample;
                mem_wdata_hi = neg_sample;
            end
            ST_RDBASE:
            begin
                mem_raddr_a = base;
                mem_raddr_b = base;
            end
            ST_EVAL:
            begin
                // Fetch the next position ahead of time; used only if nothing is flattened.
                mem_raddr_a = wrap_inc(ci_reg, size);
                mem_raddr_b = wrap_inc(ni_reg, size);
            end
            ST_FILL:
            begin
                mem_we = fill_en_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        order_next     = order_reg;
        wpos_next      = wpos_reg;
        clr_next       = clr_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        pass_next      = pass_reg;
        fill_cnt_next  = fill_cnt_reg;
        fill_en_next   = fill_en_reg;
        out_valid_next = out_valid_reg && smoothed_stall;
        idx_next       = idx_reg;
        ci_next        = ci_reg;
        ni_next        = ni_reg;
        fill_addr_next = fill_addr_reg;
        prev_lo_next   = prev_lo_reg;
        prev_hi_next   = prev_hi_reg;
        fill_lo_next   = fill_lo_reg;
        fill_hi_next   = fill_hi_reg;
        out_data_next  = out_data_reg;
        do_adv         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next   = idx_now;
                    wpos_next  = wrap_inc(idx_now, size);
                    n_next     = order_t'(1);
                    pass_next  = 1'b0;
                    state_next = ST_RDBASE;
                end
            end
            ST_RDBASE:
            begin
                i_next     = '0;
                ci_next    = ci0;
                ni_next    = ni0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                // On the first step of a sweep the base entry arrives now.
                if (i_reg == '0)
                begin
                    prev_lo_next = rd_a_lo;
                    prev_hi_next = rd_a_hi;
                end
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                prev_lo_next = upd_lo;
                prev_hi_next = upd_hi;
                if (fix.lo || fix.hi)
                begin
                    fill_en_next   = fix;
                    fill_addr_next = ci_reg;
                    fill_cnt_next  = n_reg;
                    fill_lo_next   = cmp_fill_lo;
                    fill_hi_next   = cmp_fill_hi;
                    state_next     = ST_FILL;
                end
                else
                begin
                    do_adv = 1'b1;
                end
            end
            ST_FILL:
            begin
                fill_addr_next = wrap_inc(fill_addr_reg, size);
                fill_cnt_next  = fill_cnt_reg - order_t'(1);
                if (fill_cnt_reg == order_t'(1))
                begin
                    do_adv = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !smoothed_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = diff[DW:1];
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
                clr_next   = '0;
            end
        endcase

        // Step to the next position, the second sweep, the next order, or the end.
        if (do_adv)
        begin
            priority if (!last_iter)
            begin
                i_next     = i_reg + order_t'(1);
                ci_next    = wrap_inc(ci_reg, size);
                ni_next    = wrap_inc(ni_reg, size);
                state_next = (state_reg == ST_EVAL) ? ST_EVAL : ST_RD;
            end
            else if (!pass_reg)
            begin
                pass_next  = 1'b1;
                state_next = ST_RDBASE;
            end
            else if (!last_order)
            begin
                pass_next  = 1'b0;
                n_next     = n_reg + order_t'(1);
                state_next = ST_RDBASE;
            end
            else
            begin
                state_next = ST_DONE;
            end
        end

        if (filter_order_we)
        begin
            order_next = cfg_order;
            wpos_next  = '0;
            clr_next   = '0;
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            order_reg     <= order_t'(1);
            wpos_reg      <= '0;
            clr_reg       <= '0;
            n_reg         <= order_t'(1);
            i_reg         <= '0;
            pass_reg      <= 1'b0;
            fill_cnt_reg  <= '0;
            fill_en_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            order_reg     <= order_next;
            wpos_reg      <= wpos_next;
            clr_reg       <= clr_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            pass_reg      <= pass_next;
            fill_cnt_reg  <= fill_cnt_next;
            fill_en_reg   <= fill_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        ci_reg        <= ci_next;
        ni_reg        <= ni_next;
        fill_addr_reg <= fill_addr_next;
        prev_lo_reg   <= prev_lo_next;
        prev_hi_reg   <= prev_hi_next;
        fill_lo_reg   <= fill_lo_next;
        fill_hi_reg   <= fill_hi_next;
        out_data_reg  <= out_data_next;
    end

    // In ST_RD and ST_EVAL the neighbour pointer leads ci by the order, modulo the window.
    assign ni_chk_wide = {1'b0, ci_reg} + (AW+1)'(n_reg);
    assign ni_chk      = (ni_chk_wide >= {1'b0, size}) ? AW'(ni_chk_wide - {1'b0, size})
                                                       : AW'(ni_chk_wide);

    a_order_range: assert property (@(posedge clk) disable iff (!rst_n)
        order_reg != '0 && 32'(order_reg) <= MAX_ORDER)
        else $error("filter order out of range");

    a_loop_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_EVAL || state_reg == ST_FILL)
        |-> (i_reg < n_reg && n_reg != '0 && n_reg <= order_reg))
        else $error("sweep counters out of range");

    a_ptr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_EVAL || state_reg == ST_FILL)
        |-> (ci_reg < size && ni_reg < size
             && (state_reg != ST_FILL || fill_addr_reg < size)))
        else $error("window pointer beyond window size");

    a_ptr_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_EVAL) |-> ni_reg == ni_chk)
        else $error("neighbour pointer lost its spacing");

    a_fill_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FILL |-> (fill_cnt_reg != '0 && (fill_en_reg.lo || fill_en_reg.hi)))
        else $error("write-back with no work to do");

endmodule
